// ===== sv/ffra_pkg.sv =====
// Shared types, codes and defaults of the first-fit range allocator.
package ffra_pkg;

    localparam int FREE_SLOTS_DEF   = 64;
    localparam int HANDLE_SLOTS_DEF = 256;
    localparam int UNIT_BITS_DEF    = 32;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_FIT     = 3'd1;
    localparam logic [2:0] ST_NO_HANDLE  = 3'd2;
    localparam logic [2:0] ST_LIST_FULL  = 3'd3;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd4;
    localparam logic [2:0] ST_ZERO_SIZE  = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] req_size;
        logic [7:0]  req_handle;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  handle;
        logic [31:0] offset;
        logic [31:0] length;
    } out_word_t;

    // Free-list write data selection.
    typedef enum logic [2:0] {
        FW_SEED, FW_SPLIT, FW_COPY, FW_MERGE2, FW_LEFT, FW_RIGHT, FW_NEW
    } fwd_sel_t;

    // Free-list write address selection.
    typedef enum logic [1:0] {FA_ZERO, FA_IDX, FA_IDXM1, FA_K} fwa_sel_t;

    // Free-list read address selection.
    typedef enum logic [1:0] {FR_IDX, FR_KP1, FR_KM1} frd_sel_t;

    typedef struct packed {
        logic       accept;
        logic       seed;
        logic       fr_re;
        frd_sel_t   frd_sel;
        logic       fr_we;
        fwa_sel_t   fwa_sel;
        fwd_sel_t   fwd_sel;
        logic       idx_clr;
        logic       idx_inc;
        logic       k_load_idx;
        logic       k_load_cnt;
        logic       k_inc;
        logic       k_dec;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       prev_ld;
        logic       cur_ld;
        logic       fit_ld;
        logic       rng_ld;
        logic       h_rd;
        logic       h_rd_head;
        logic       pop_link;
        logic       take_fresh;
        logic       h_wr_alloc;
        logic       rel_commit;
        logic       st_ld;
        logic [2:0] st_code;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       size_zero;
        logic       no_handle;
        logic       h_ok;
        logic       idx_lt_cnt;
        logic       idx_nz;
        logic       fit;
        logic       exact;
        logic       below;
        logic       ml;
        logic       mr;
        logic       full;
        logic       head_nz;
        logic       kp1_lt_cnt;
        logic       k_gt_idx;
        logic       seed_pend;
        logic       out_free;
    } stat_t;

endpackage

// ===== sv/ffra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== sv/ffra_ctrl.sv =====
// Controller state machine that sequences every request through the datapath.
module ffra_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ffra_pkg::stat_t st,
    output ffra_pkg::cmd_t  cmd
);
    import ffra_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_A_RD, S_A_CHK, S_A_HDL, S_A_LNK, S_A_WR,
        S_SL_RD, S_SL_WR, S_R_HCAP, S_R_RD, S_R_CHK, S_R_DEC,
        S_SR_RD, S_SR_WR, S_R_DONE, S_L_CAP, S_FIN
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE) && !st.seed_pend;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (st.seed_pend) begin
                    cmd.seed    = 1'b1;
                    cmd.fr_we   = 1'b1;
                    cmd.fwa_sel = FA_ZERO;
                    cmd.fwd_sel = FW_SEED;
                end else if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cmd.idx_clr = 1'b1;
                priority if (st.mode == MODE_ALLOC) begin
                    priority if (st.size_zero) begin
                        cmd.st_ld = 1'b1; cmd.st_code = ST_ZERO_SIZE; state_next = S_FIN;
                    end else if (st.no_handle) begin
                        cmd.st_ld = 1'b1; cmd.st_code = ST_NO_HANDLE; state_next = S_FIN;
                    end else begin
                        state_next = S_A_RD;
                    end
                end else if ((st.mode == MODE_RELEASE || st.mode == MODE_LOOKUP) && st.h_ok) begin
                    cmd.h_rd   = 1'b1;
                    state_next = (st.mode == MODE_RELEASE) ? S_R_HCAP : S_L_CAP;
                end else begin
                    cmd.st_ld = 1'b1; cmd.st_code = ST_BAD_HANDLE; state_next = S_FIN;
                end
            end
            S_A_RD: begin
                if (st.idx_lt_cnt) begin
                    cmd.fr_re = 1'b1; cmd.frd_sel = FR_IDX; state_next = S_A_CHK;
                end else begin
                    cmd.st_ld = 1'b1; cmd.st_code = ST_NO_FIT; state_next = S_FIN;
                end
            end
            S_A_CHK: begin
                if (st.fit) begin
                    cmd.fit_ld = 1'b1;
                    if (st.exact) begin
                        cmd.k_load_idx = 1'b1; state_next = S_SL_RD;
                    end else begin
                        cmd.fr_we = 1'b1; cmd.fwa_sel = FA_IDX; cmd.fwd_sel = FW_SPLIT;
                        state_next = S_A_HDL;
                    end
                end else begin
                    cmd.idx_inc = 1'b1; state_next = S_A_RD;
                end
            end
            S_A_HDL: begin
                if (st.head_nz) begin
                    cmd.h_rd = 1'b1; cmd.h_rd_head = 1'b1; state_next = S_A_LNK;
                end else begin
                    cmd.take_fresh = 1'b1; state_next = S_A_WR;
                end
            end
            S_A_LNK: begin
                cmd.pop_link = 1'b1; state_next = S_A_WR;
            end
            S_A_WR: begin
                cmd.h_wr_alloc = 1'b1;
                cmd.st_ld = 1'b1; cmd.st_code = ST_OK; state_next = S_FIN;
            end
            S_SL_RD: begin
                if (st.kp1_lt_cnt) begin
                    cmd.fr_re = 1'b1; cmd.frd_sel = FR_KP1; state_next = S_SL_WR;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = (st.mode == MODE_ALLOC) ? S_A_HDL : S_R_DONE;
                end
            end
            S_SL_WR: begin
                cmd.fr_we = 1'b1; cmd.fwa_sel = FA_K; cmd.fwd_sel = FW_COPY;
                cmd.k_inc = 1'b1; state_next = S_SL_RD;
            end
            S_R_HCAP: begin
                cmd.rng_ld = 1'b1; state_next = S_R_RD;
            end
            S_R_RD: begin
                if (st.idx_lt_cnt) begin
                    cmd.fr_re = 1'b1; cmd.frd_sel = FR_IDX; state_next = S_R_CHK;
                end else begin
                    state_next = S_R_DEC;
                end
            end
            S_R_CHK: begin
                cmd.cur_ld = 1'b1;
                if (st.below) begin
                    cmd.prev_ld = 1'b1; cmd.idx_inc = 1'b1; state_next = S_R_RD;
                end else begin
                    state_next = S_R_DEC;
                end
            end
            S_R_DEC: begin
                priority if (st.ml && st.mr) begin
                    cmd.fr_we = 1'b1; cmd.fwa_sel = FA_IDXM1; cmd.fwd_sel = FW_MERGE2;
                    cmd.k_load_idx = 1'b1; state_next = S_SL_RD;
                end else if (st.ml) begin
                    cmd.fr_we = 1'b1; cmd.fwa_sel = FA_IDXM1; cmd.fwd_sel = FW_LEFT;
                    state_next = S_R_DONE;
                end else if (st.mr) begin
                    cmd.fr_we = 1'b1; cmd.fwa_sel = FA_IDX; cmd.fwd_sel = FW_RIGHT;
                    state_next = S_R_DONE;
                end else if (st.full) begin
                    cmd.st_ld = 1'b1; cmd.st_code = ST_LIST_FULL; state_next = S_FIN;
                end else begin
                    cmd.k_load_cnt = 1'b1; state_next = S_SR_RD;
                end
            end
            S_SR_RD: begin
                if (st.k_gt_idx) begin
                    cmd.fr_re = 1'b1; cmd.frd_sel = FR_KM1; state_next = S_SR_WR;
                end else begin
                    cmd.fr_we = 1'b1; cmd.fwa_sel = FA_IDX; cmd.fwd_sel = FW_NEW;
                    cmd.cnt_inc = 1'b1; state_next = S_R_DONE;
                end
            end
            S_SR_WR: begin
                cmd.fr_we = 1'b1; cmd.fwa_sel = FA_K; cmd.fwd_sel = FW_COPY;
                cmd.k_dec = 1'b1; state_next = S_SR_RD;
            end
            S_R_DONE: begin
                cmd.rel_commit = 1'b1;
                cmd.st_ld = 1'b1; cmd.st_code = ST_OK; state_next = S_FIN;
            end
            S_L_CAP: begin
                cmd.rng_ld = 1'b1;
                cmd.st_ld = 1'b1; cmd.st_code = ST_OK; state_next = S_FIN;
            end
            S_FIN: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== sv/ffra_dp.sv =====
// Datapath: free list and handle memories, bookkeeping registers, result word.
module ffra_dp #(
    parameter int FREE_SLOTS   = ffra_pkg::FREE_SLOTS_DEF,
    parameter int HANDLE_SLOTS = ffra_pkg::HANDLE_SLOTS_DEF,
    parameter int UNIT_BITS    = ffra_pkg::UNIT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ffra_pkg::in_word_t  s_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [31:0]         cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffra_pkg::out_word_t m_data,
    input  ffra_pkg::cmd_t      cmd,
    output ffra_pkg::stat_t     st
);
    import ffra_pkg::*;

    localparam int FW = $clog2(FREE_SLOTS);
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam int HW = $clog2(HANDLE_SLOTS);
    localparam int U  = UNIT_BITS;
    localparam logic [CW-1:0] CNT_FULL   = CW'(FREE_SLOTS);
    localparam logic [HW:0]   FRESH_LAST = (HW + 1)'(HANDLE_SLOTS);

    logic [31:0]       pool_reg;
    logic              seed_pend_reg;
    logic [1:0]        mode_reg;
    logic [U-1:0]      size_reg;
    logic [7:0]        req_h_reg;
    logic [HW-1:0]     hdl_reg;
    logic [CW-1:0]     idx_reg, k_reg, cnt_reg;
    logic [HW-1:0]     head_reg, id_reg;
    logic [HW:0]       fresh_reg;
    logic [HANDLE_SLOTS-1:0] live_reg;
    logic [U-1:0]      off_reg, sz_reg, prev_s_reg, prev_l_reg, cur_s_reg, cur_l_reg;
    logic [2:0]        st_reg;
    logic              m_valid_reg;
    out_word_t         m_data_reg;

    logic              fr_we, fr_re;
    logic [FW-1:0]     fr_waddr, fr_raddr;
    logic [2*U-1:0]    fr_wdata, fr_rdata;
    logic [U-1:0]      rd_s, rd_l, pool_u, prev_end, off_end;
    logic [HW-1:0]     h_raddr, h_waddr;
    logic              hs_we, hl_we;
    logic [U-1:0]      hs_wdata, hs_rdata, hl_rdata;

    assign rd_s     = fr_rdata[2*U-1:U];
    assign rd_l     = fr_rdata[U-1:0];
    assign pool_u   = U'(pool_reg);
    assign prev_end = prev_s_reg + prev_l_reg;
    assign off_end  = off_reg + sz_reg;

    // Free-list port muxes.
    assign fr_we = cmd.fr_we;
    assign fr_re = cmd.fr_re;
    always_comb begin
        unique case (cmd.fwa_sel)
            FA_ZERO:  fr_waddr = '0;
            FA_IDX:   fr_waddr = FW'(idx_reg);
            FA_IDXM1: fr_waddr = FW'(idx_reg - 1'b1);
            FA_K:     fr_waddr = FW'(k_reg);
            default:  fr_waddr = '0;
        endcase
        unique case (cmd.frd_sel)
            FR_IDX:  fr_raddr = FW'(idx_reg);
            FR_KP1:  fr_raddr = FW'(k_reg + 1'b1);
            FR_KM1:  fr_raddr = FW'(k_reg - 1'b1);
            default: fr_raddr = FW'(idx_reg);
        endcase
        unique case (cmd.fwd_sel)
            FW_SEED:   fr_wdata = {{U{1'b0}}, pool_u};
            FW_SPLIT:  fr_wdata = {rd_s + size_reg, rd_l - size_reg};
            FW_COPY:   fr_wdata = fr_rdata;
            FW_MERGE2: fr_wdata = {prev_s_reg, prev_l_reg + sz_reg + cur_l_reg};
            FW_LEFT:   fr_wdata = {prev_s_reg, prev_l_reg + sz_reg};
            FW_RIGHT:  fr_wdata = {off_reg, cur_l_reg + sz_reg};
            FW_NEW:    fr_wdata = {off_reg, sz_reg};
            default:   fr_wdata = fr_rdata;
        endcase
    end

    // Handle store ports: start (or recycle link) and length.
    assign h_raddr  = cmd.h_rd_head ? head_reg : hdl_reg;
    assign h_waddr  = cmd.h_wr_alloc ? id_reg : hdl_reg;
    assign hs_we    = cmd.h_wr_alloc || cmd.rel_commit;
    assign hl_we    = cmd.h_wr_alloc;
    assign hs_wdata = cmd.h_wr_alloc ? off_reg : U'(head_reg);

    ffra_ram #(.WIDTH(2 * U), .DEPTH(FREE_SLOTS)) u_free_ram (
        .aclk(aclk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
        .re(fr_re), .raddr(fr_raddr), .rdata(fr_rdata)
    );
    ffra_ram #(.WIDTH(U), .DEPTH(HANDLE_SLOTS)) u_hstart_ram (
        .aclk(aclk), .we(hs_we), .waddr(h_waddr), .wdata(hs_wdata),
        .re(cmd.h_rd), .raddr(h_raddr), .rdata(hs_rdata)
    );
    ffra_ram #(.WIDTH(U), .DEPTH(HANDLE_SLOTS)) u_hlen_ram (
        .aclk(aclk), .we(hl_we), .waddr(h_waddr), .wdata(size_reg),
        .re(cmd.h_rd), .raddr(h_raddr), .rdata(hl_rdata)
    );

    // Status toward the controller.
    always_comb begin
        st.mode       = mode_reg;
        st.size_zero  = (size_reg == '0);
        st.no_handle  = (head_reg == '0) && (fresh_reg >= FRESH_LAST);
        st.h_ok       = (req_h_reg != 8'd0) && (32'(req_h_reg) < 32'(HANDLE_SLOTS))
                        && live_reg[hdl_reg];
        st.idx_lt_cnt = (idx_reg < cnt_reg);
        st.idx_nz     = (idx_reg != '0);
        st.fit        = (rd_l >= size_reg);
        st.exact      = (rd_l == size_reg);
        st.below      = (rd_s < off_reg);
        st.ml         = (idx_reg != '0) && (prev_end == off_reg);
        st.mr         = (idx_reg < cnt_reg) && (off_end == cur_s_reg);
        st.full       = (cnt_reg >= CNT_FULL);
        st.head_nz    = (head_reg != '0);
        st.kp1_lt_cnt = (({1'b0, k_reg} + 1'b1) < {1'b0, cnt_reg});
        st.k_gt_idx   = (k_reg > idx_reg);
        st.seed_pend  = seed_pend_reg;
        st.out_free   = !m_valid_reg || m_ready;
    end

    // Control registers; a configuration write restarts the allocator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg      <= '1;
            seed_pend_reg <= 1'b1;
            cnt_reg       <= CW'(1);
            head_reg      <= '0;
            fresh_reg     <= (HW + 1)'(1);
            live_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                pool_reg      <= cfg_data;
                seed_pend_reg <= 1'b1;
                cnt_reg       <= CW'(U'(cfg_data) != '0);
                head_reg      <= '0;
                fresh_reg     <= (HW + 1)'(1);
                live_reg      <= '0;
            end else begin
                if (cmd.seed) begin
                    seed_pend_reg <= 1'b0;
                end
                if (cmd.cnt_inc && cnt_reg < CNT_FULL) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end else if (cmd.cnt_dec && cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                if (cmd.pop_link) begin
                    head_reg <= HW'(hs_rdata);
                end else if (cmd.rel_commit) begin
                    head_reg <= hdl_reg;
                end
                if (cmd.take_fresh && fresh_reg < FRESH_LAST) begin
                    fresh_reg <= fresh_reg + 1'b1;
                end
                if (cmd.h_wr_alloc) begin
                    live_reg[id_reg] <= 1'b1;
                end else if (cmd.rel_commit) begin
                    live_reg[hdl_reg] <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg  <= s_data.mode;
            size_reg  <= U'(s_data.req_size);
            req_h_reg <= s_data.req_handle;
            hdl_reg   <= HW'(s_data.req_handle);
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.k_load_idx) begin
            k_reg <= idx_reg;
        end else if (cmd.k_load_cnt) begin
            k_reg <= cnt_reg;
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + 1'b1;
        end else if (cmd.k_dec) begin
            k_reg <= k_reg - 1'b1;
        end
        if (cmd.prev_ld) begin
            prev_s_reg <= rd_s;
            prev_l_reg <= rd_l;
        end
        if (cmd.cur_ld) begin
            cur_s_reg <= rd_s;
            cur_l_reg <= rd_l;
        end
        if (cmd.fit_ld) begin
            off_reg <= rd_s;
            sz_reg  <= size_reg;
        end else if (cmd.rng_ld) begin
            off_reg <= hs_rdata;
            sz_reg  <= hl_rdata;
        end
        if (cmd.pop_link) begin
            id_reg <= head_reg;
        end else if (cmd.take_fresh) begin
            id_reg <= HW'(fresh_reg);
        end else if (cmd.rng_ld) begin
            id_reg <= hdl_reg;
        end
        if (cmd.st_ld) begin
            st_reg <= cmd.st_code;
        end
        if (cmd.emit) begin
            m_data_reg.status <= st_reg;
            if (st_reg == ST_OK) begin
                m_data_reg.handle <= 8'(id_reg);
                m_data_reg.offset <= 32'(off_reg);
                m_data_reg.length <= 32'(sz_reg);
            end else begin
                m_data_reg.handle <= '0;
                m_data_reg.offset <= '0;
                m_data_reg.length <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("free block count above capacity");
    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= FRESH_LAST && fresh_reg != '0)
        else $error("fresh handle counter out of range");
    a_cfg_reseed: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> seed_pend_reg && head_reg == '0 && live_reg == '0)
        else $error("configuration write did not restart the allocator");
endmodule

// ===== sv/first_fit_range_allocator_top.sv =====
// Top level of the first-fit range allocator with coalescing.
//
//   channel   direction  ports                         word
//   request   in         s_valid s_ready s_data        mode, req_size, req_handle
//   result    out        m_valid m_ready m_data        status, handle, offset, length
//   config    in         cfg_valid cfg_ready cfg_data  pool_size
//
// One request word is in flight at a time. An allocate walks the free list entry by
// entry (the free-list memory has one read port with registered data), then removing
// an exactly fitting block shifts the tail down one entry at a time; a release walks
// the list the same way, then shifts the tail down after a merge with both neighbours,
// or up to insert a new block when it merges with neither. Lookups, and requests
// refused on their own fields, skip the walk.
// After reset, and after each pool_size write, the block writes the seed block into
// the free list before it raises s_ready.
// A finished result sits in the output register while the next request word is
// accepted; a stall on m_ready holds only the final hand-over of that next result.
module first_fit_range_allocator_top #(
    parameter int FREE_SLOTS   = ffra_pkg::FREE_SLOTS_DEF,
    parameter int HANDLE_SLOTS = ffra_pkg::HANDLE_SLOTS_DEF,
    parameter int UNIT_BITS    = ffra_pkg::UNIT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffra_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffra_pkg::out_word_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);
    import ffra_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // The configuration register is always writable; writes must only be issued while
    // the block is idle, a rule on the user that the block itself does not enforce.
    assign cfg_ready = 1'b1;

    ffra_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .st(st), .cmd(cmd)
    );

    ffra_dp #(
        .FREE_SLOTS(FREE_SLOTS), .HANDLE_SLOTS(HANDLE_SLOTS), .UNIT_BITS(UNIT_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .s_data(s_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cmd(cmd), .st(st)
    );
endmodule
